// File: hw/rtl/dmms_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dmms_pkg: shared types and constants for the medoid select block
// Holds the job handoff type, fixed output widths and the popcount helper.
// ============================================================================
package dmms_pkg;

    localparam int WORD_W    = 64;
    localparam int OUT_BITS  = 256;
    localparam int IDX_OUT_W = 6;
    localparam int MED_OUT_W = 9;
    localparam int PC_W      = 7;

    // A finished set, handed from the loader to the selector.
    typedef struct packed {
        logic valid;
        logic overflow;
    } dmms_job_t;

    function automatic logic [PC_W-1:0] popcount64(input logic [WORD_W-1:0] v);
        logic [PC_W-1:0] c;
        c = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            c = c + PC_W'(v[b]);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/descriptor_median_medoid_select.sv
`timescale 1ns / 1ps
// Result: the last request of a set yields its result once the selector has ranked every row
// of the N stored descriptors (bitwise rank search, one row-memory read per cycle), or
// without a search for an empty set.
// Throughput: one request per cycle while in_ready is high; the next set may load while
// a result waits, but not while a set is queued or the selector is working on one.
// Reset: asynchronous, active low; clears the loader counters, flags and handshakes.
// ============================================================================
// descriptor_median_medoid_select: minimum median Hamming medoid selector
// Loads a set of binary descriptors and returns the one whose median Hamming
// distance to the set is smallest, lowest index first on a tie.
// ============================================================================
module descriptor_median_medoid_select #(
    parameter int MAX_DESC  = 64,
    parameter int DESC_BITS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dmms_pkg::WORD_W-1:0]     desc_word0,
    input  logic [dmms_pkg::WORD_W-1:0]     desc_word1,
    input  logic [dmms_pkg::WORD_W-1:0]     desc_word2,
    input  logic [dmms_pkg::WORD_W-1:0]     desc_word3,
    input  logic                            entry_valid,
    input  logic                            last_entry,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [dmms_pkg::IDX_OUT_W-1:0]  best_index,
    output logic [dmms_pkg::MED_OUT_W-1:0]  best_median,
    output logic                            overflow,
    output logic [dmms_pkg::WORD_W-1:0]     out_word0,
    output logic [dmms_pkg::WORD_W-1:0]     out_word1,
    output logic [dmms_pkg::WORD_W-1:0]     out_word2,
    output logic [dmms_pkg::WORD_W-1:0]     out_word3
);
    import dmms_pkg::*;

    localparam int IDX_W = $clog2(MAX_DESC);
    localparam int CNT_W = $clog2(MAX_DESC + 1);

    // Store write side, owned by the loader.
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [DESC_BITS-1:0] wr_data;

    // Store read side, owned by the selector.
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [DESC_BITS-1:0] rd_data;

    // One-entry set queue between loader and selector. The loader pushes on the
    // last request of a set; the selector pops when it is idle and its output register is free.
    dmms_job_t            job;
    logic [CNT_W-1:0]     job_count;
    logic                 job_pop;
    logic                 back_busy;

    // The loader stores valid descriptors in arrival order and flags any dropped for lack of room.
    dmms_front #(
        .MAX_DESC  (MAX_DESC),
        .DESC_BITS (DESC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .desc_word0  (desc_word0),
        .desc_word1  (desc_word1),
        .desc_word2  (desc_word2),
        .desc_word3  (desc_word3),
        .entry_valid (entry_valid),
        .last_entry  (last_entry),
        .back_busy   (back_busy),
        .job_pop     (job_pop),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .job         (job),
        .job_count   (job_count)
    );

    // The descriptor memory, written by the loader and read by the selector.
    dmms_store #(
        .DEPTH (MAX_DESC),
        .WIDTH (DESC_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The selector walks each row of pairwise distances, finds its median by a
    // bit-at-a-time rank search, and holds the result in an output register so
    // the next set can load while the result waits.
    dmms_back #(
        .MAX_DESC  (MAX_DESC),
        .DESC_BITS (DESC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .job_count   (job_count),
        .job_pop     (job_pop),
        .busy        (back_busy),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .best_index  (best_index),
        .best_median (best_median),
        .overflow    (overflow),
        .out_word0   (out_word0),
        .out_word1   (out_word1),
        .out_word2   (out_word2),
        .out_word3   (out_word3)
    );

endmodule

// File: hw/rtl/dmms_store.sv
`timescale 1ns / 1ps
// ============================================================================
// dmms_store: descriptor memory
// One write port from the loader, one registered read port for the selector.
// ============================================================================
module dmms_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/dmms_front.sv
`timescale 1ns / 1ps
// ============================================================================
// dmms_front: descriptor loader
// Takes one request per cycle while in_ready is high, stores valid descriptors and queues the set.
// ============================================================================
module dmms_front #(
    parameter int MAX_DESC  = 64,
    parameter int DESC_BITS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dmms_pkg::WORD_W-1:0]       desc_word0,
    input  logic [dmms_pkg::WORD_W-1:0]       desc_word1,
    input  logic [dmms_pkg::WORD_W-1:0]       desc_word2,
    input  logic [dmms_pkg::WORD_W-1:0]       desc_word3,
    input  logic                              entry_valid,
    input  logic                              last_entry,
    input  logic                              back_busy,
    input  logic                              job_pop,
    output logic                              wr_en,
    output logic [$clog2(MAX_DESC)-1:0]       wr_addr,
    output logic [DESC_BITS-1:0]              wr_data,
    output dmms_pkg::dmms_job_t               job,
    output logic [$clog2(MAX_DESC+1)-1:0]     job_count
);
    import dmms_pkg::*;

    localparam int IDX_W = $clog2(MAX_DESC);
    localparam int CNT_W = $clog2(MAX_DESC + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             job_valid_reg, job_valid_next;
    logic             job_ovf_reg, job_ovf_next;
    logic [CNT_W-1:0] job_count_reg, job_count_next;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] count_after;
    logic             ovf_after;

    // The store is shared with the selector, so loading waits while a set is queued
    // or being worked on.
    assign in_ready    = !job_valid_reg && !back_busy;
    assign accept      = in_valid && in_ready;
    assign room        = count_reg < CNT_W'(MAX_DESC);
    assign wr_en       = accept && entry_valid && room;
    assign wr_addr     = count_reg[IDX_W-1:0];
    assign wr_data     = DESC_BITS'({desc_word3, desc_word2, desc_word1, desc_word0});
    assign count_after = wr_en ? count_reg + CNT_W'(1) : count_reg;
    assign ovf_after   = ovf_reg || (accept && entry_valid && !room);

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        job_valid_next = job_valid_reg;
        job_ovf_next   = job_ovf_reg;
        job_count_next = job_count_reg;
        if (job_pop)
        begin
            job_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (last_entry)
            begin
                count_next     = '0;
                ovf_next       = 1'b0;
                job_valid_next = 1'b1;
                job_ovf_next   = ovf_after;
                job_count_next = count_after;
            end
            else
            begin
                count_next = count_after;
                ovf_next   = ovf_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            job_valid_reg <= 1'b0;
            job_ovf_reg   <= 1'b0;
            job_count_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            job_valid_reg <= job_valid_next;
            job_ovf_reg   <= job_ovf_next;
            job_count_reg <= job_count_next;
        end
    end

    assign job.valid    = job_valid_reg;
    assign job.overflow = job_ovf_reg;
    assign job_count    = job_count_reg;

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg < CNT_W'(MAX_DESC)))
        else $error("store write beyond capacity");

    a_pop_when_queued: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (job_valid_reg && !accept))
        else $error("job popped while empty or while loading");

endmodule

// File: hw/rtl/dmms_back.sv
`timescale 1ns / 1ps
// ============================================================================
// dmms_back: medoid selector
// Builds each distance row, finds its median by a bitwise rank search and
// keeps the descriptor with the smallest median.
// ============================================================================
module dmms_back #(
    parameter int MAX_DESC  = 64,
    parameter int DESC_BITS = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmms_pkg::dmms_job_t                  job,
    input  logic [$clog2(MAX_DESC+1)-1:0]        job_count,
    output logic                                 job_pop,
    output logic                                 busy,
    output logic                                 rd_en,
    output logic [$clog2(MAX_DESC)-1:0]          rd_addr,
    input  logic [DESC_BITS-1:0]                 rd_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 found,
    output logic [dmms_pkg::IDX_OUT_W-1:0]       best_index,
    output logic [dmms_pkg::MED_OUT_W-1:0]       best_median,
    output logic                                 overflow,
    output logic [dmms_pkg::WORD_W-1:0]          out_word0,
    output logic [dmms_pkg::WORD_W-1:0]          out_word1,
    output logic [dmms_pkg::WORD_W-1:0]          out_word2,
    output logic [dmms_pkg::WORD_W-1:0]          out_word3
);
    import dmms_pkg::*;

    localparam int IDX_W = $clog2(MAX_DESC);
    localparam int CNT_W = $clog2(MAX_DESC + 1);
    localparam int MED_W = $clog2(DESC_BITS + 1);
    localparam int BIT_W = $clog2(MED_W);
    localparam int NW    = (DESC_BITS + WORD_W - 1) / WORD_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_FETCH_I = 9'b000000010,
        S_LATCH_I = 9'b000000100,
        S_DIST    = 9'b000001000,
        S_DRAIN   = 9'b000010000,
        S_SRCH    = 9'b000100000,
        S_DECIDE  = 9'b001000000,
        S_FETCH_W = 9'b010000000,
        S_WRAP    = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic              ovf_reg, ovf_next;
    logic [DESC_BITS-1:0] di_reg;
    logic              v1_reg, v2_reg;
    logic [IDX_W-1:0]  j1_reg, j2_reg;
    logic [PC_W-1:0]   pc_reg [NW];
    logic [MED_W-1:0]  row_mem [MAX_DESC];
    logic              row_rd_en;
    logic              rrv_reg;
    logic [MED_W-1:0]  rrd_reg;
    logic [MED_W-1:0]  x_reg, x_next;
    logic [BIT_W-1:0]  b_reg, b_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MED_W-1:0]  best_med_reg, best_med_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic              out_ovf_reg, out_ovf_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [MED_W-1:0]  out_med_reg, out_med_next;
    logic [DESC_BITS-1:0] out_desc_reg, out_desc_next;
    logic [CNT_W-1:0]  n_minus1;
    logic [NW*WORD_W-1:0] xd;
    logic [MED_W-1:0]  row_sum;
    logic [MED_W-1:0]  cand;
    logic              lt;
    logic [CNT_W-1:0]  cnt_total;
    logic [MED_W-1:0]  x_new;
    logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
    logic [OUT_BITS-1:0] desc_ext;

    assign n_minus1  = job_count - CNT_W'(1);
    assign xd        = (NW*WORD_W)'(rd_data ^ di_reg);
    assign cand      = x_reg | (MED_W'(1) << b_reg);
    assign lt        = rrv_reg && (rrd_reg < cand);
    assign cnt_total = cnt_reg + CNT_W'(lt);
    assign x_new     = (cnt_total <= CNT_W'(k_reg)) ? cand : x_reg;
    assign busy      = (state_reg != S_IDLE);
    assign job_pop   = (state_reg == S_IDLE) && job.valid && !out_valid_reg;
    assign row_rd_en = (state_reg == S_SRCH);

    always_comb
    begin
        row_sum = '0;
        for (int w = 0; w < NW; w++)
        begin
            row_sum = row_sum + MED_W'(pc_reg[w]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        x_next         = x_reg;
        b_next         = b_reg;
        cnt_next       = cnt_reg;
        best_med_next  = best_med_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_found_next = out_found_reg;
        out_ovf_next   = out_ovf_reg;
        out_idx_next   = out_idx_reg;
        out_med_next   = out_med_reg;
        out_desc_next  = out_desc_reg;
        rd_en          = 1'b0;
        rd_addr        = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_pop)
                begin
                    ovf_next      = job.overflow;
                    best_med_next = '1;
                    best_idx_next = '0;
                    if (job_count == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_found_next = 1'b0;
                        out_ovf_next   = job.overflow;
                        out_idx_next   = '0;
                        out_med_next   = '0;
                        out_desc_next  = '0;
                    end
                    else
                    begin
                        last_next  = n_minus1[IDX_W-1:0];
                        k_next     = IDX_W'(n_minus1 >> 1);
                        i_next     = '0;
                        state_next = S_FETCH_I;
                    end
                end
            end
            S_FETCH_I:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = S_LATCH_I;
            end
            S_LATCH_I:
            begin
                j_next     = '0;
                state_next = S_DIST;
            end
            S_DIST:
            begin
                rd_en   = 1'b1;
                rd_addr = j_reg;
                if (j_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    j_next     = '0;
                    x_next     = '0;
                    b_next     = BIT_W'(MED_W - 1);
                    cnt_next   = '0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                cnt_next = cnt_total;
                if (j_reg == last_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_DECIDE:
            begin
                cnt_next = '0;
                j_next   = '0;
                if (b_reg == '0)
                begin
                    if (x_new < best_med_reg)
                    begin
                        best_med_next = x_new;
                        best_idx_next = i_reg;
                    end
                    if (i_reg == last_reg)
                    begin
                        state_next = S_FETCH_W;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_FETCH_I;
                    end
                end
                else
                begin
                    x_next     = x_new;
                    b_next     = b_reg - BIT_W'(1);
                    state_next = S_SRCH;
                end
            end
            S_FETCH_W:
            begin
                rd_en      = 1'b1;
                rd_addr    = best_idx_reg;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                out_valid_next = 1'b1;
                out_found_next = 1'b1;
                out_ovf_next   = ovf_reg;
                out_idx_next   = best_idx_reg;
                out_med_next   = best_med_reg;
                out_desc_next  = rd_data;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rrv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            best_med_reg  <= '1;
            best_idx_reg  <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            v1_reg        <= (state_reg == S_DIST);
            v2_reg        <= v1_reg;
            rrv_reg       <= row_rd_en;
            out_valid_reg <= out_valid_next;
            best_med_reg  <= best_med_next;
            best_idx_reg  <= best_idx_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        last_reg      <= last_next;
        k_reg         <= k_next;
        x_reg         <= x_next;
        b_reg         <= b_next;
        cnt_reg       <= cnt_next;
        out_found_reg <= out_found_next;
        out_ovf_reg   <= out_ovf_next;
        out_idx_reg   <= out_idx_next;
        out_med_reg   <= out_med_next;
        out_desc_reg  <= out_desc_next;
        j1_reg        <= j_reg;
        j2_reg        <= j1_reg;
        if (state_reg == S_LATCH_I)
        begin
            di_reg <= rd_data;
        end
        for (int w = 0; w < NW; w++)
        begin
            pc_reg[w] <= popcount64(xd[w*WORD_W +: WORD_W]);
        end
        if (v2_reg)
        begin
            row_mem[j2_reg] <= row_sum;
        end
        if (row_rd_en)
        begin
            rrd_reg <= row_mem[j_reg];
        end
    end

    assign idx_ext     = (IDX_W+IDX_OUT_W)'(out_idx_reg);
    assign desc_ext    = OUT_BITS'(out_desc_reg);
    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign overflow    = out_ovf_reg;
    assign best_index  = idx_ext[IDX_OUT_W-1:0];
    assign best_median = MED_OUT_W'(out_med_reg);
    assign out_word0   = desc_ext[0*WORD_W +: WORD_W];
    assign out_word1   = desc_ext[1*WORD_W +: WORD_W];
    assign out_word2   = desc_ext[2*WORD_W +: WORD_W];
    assign out_word3   = desc_ext[3*WORD_W +: WORD_W];

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (row_sum <= MED_W'(DESC_BITS)))
        else $error("row distance exceeds descriptor width");

    a_decide_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> rrv_reg)
        else $error("rank decision without final row read");

    a_median_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRAP) |-> (best_med_reg <= MED_W'(DESC_BITS)))
        else $error("selected median out of range");

endmodule
